>>> src/seen_id_table_with_age_out_assert.svh
// Assertion macros for the seen-ID table with age-out.
`ifndef SEEN_ID_TABLE_WITH_AGE_OUT_ASSERT_SVH
`define SEEN_ID_TABLE_WITH_AGE_OUT_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every clock edge outside reset.
`define SEEN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("seen table check failed: label");

// Next-cycle implication.
`define SEEN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("seen table check failed: label");

`else

`define SEEN_ASSERT_NOW(label, ante, cons)
`define SEEN_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/seen_pkg.sv
// Shared constants and types for the seen-ID table with age-out.
package seen_pkg;

  localparam int SEEN_TABLE_DEPTH = 1024;
  localparam int SEEN_ID_BYTES    = 12;
  localparam int SEEN_NUM_CELLS   = 8;

  localparam int LEN_W   = 4;
  localparam int HITS_W  = 16;
  localparam int TIME_W  = 32;
  localparam int AGE_W   = 16;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 40;
  localparam int ID_LOW_W  = 64;
  localparam int ID_HIGH_W = 32;
  localparam int OUT_CNT_W = 11;

  localparam logic [AGE_W-1:0]  MAX_AGE_RESET      = 16'd300;
  localparam logic [AGE_W-1:0]  SWEEP_PERIOD_RESET = 16'd60;
  localparam logic [HITS_W-1:0] HITS_MAX           = 16'hFFFF;

  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  localparam logic REG_MAX_AGE      = 1'b0;
  localparam logic REG_SWEEP_PERIOD = 1'b1;

  typedef struct packed {
    logic clear;
    logic rd_en;
    logic start;
    logic obs;
    logic sweep;
  } seen_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [HITS_W-1:0] hits;
  } seen_hit_t;

endpackage

>>> src/seen_cell.sv
// One table cell: a bank of entries, its scan stage and its link in the summary chain.
module seen_cell import seen_pkg::*; #(
  parameter int BANK    = 128,
  parameter int AW      = 7,
  parameter int IDW     = 96,
  parameter int EW      = 11,
  parameter int ENTRIES = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  seen_ctrl_t       ctrl_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [IDW-1:0]   qid_i,
  input  logic [LEN_W-1:0] qlen_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic [AGE_W-1:0] max_age_i,
  input  seen_hit_t        hit_i,
  input  logic [EW-1:0]    evict_i,
  input  logic             tok_i,
  output seen_hit_t        hit_o,
  output logic [EW-1:0]    evict_o,
  output logic             tok_o
);

  localparam int ENW = 1 + LEN_W + HITS_W + TIME_W + IDW;

  logic [ENW-1:0] mem_q [BANK];
  logic [ENW-1:0] rdata_q;

  logic          s1_vld_q;
  logic [AW-1:0] s1_addr_q;

  logic              hit_q;
  logic [HITS_W-1:0] hits_q;
  logic [EW-1:0]     evict_q;
  logic              free_q;
  logic [AW-1:0]     free_addr_q;

  seen_hit_t     hit_o_q;
  logic [EW-1:0] evict_o_q;
  logic          tok_q;

  logic              r_valid;
  logic [LEN_W-1:0]  r_len;
  logic [HITS_W-1:0] r_hits;
  logic [TIME_W-1:0] r_time;
  logic [IDW-1:0]    r_id;
  logic [TIME_W-1:0] age;
  logic [HITS_W-1:0] hits_inc;
  logic              exists;
  logic              hit_now;
  logic              old_now;
  logic              free_now;
  logic              take;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [ENW-1:0] wdata;

  assign r_valid = rdata_q[ENW-1];
  assign r_len   = rdata_q[ENW-2 -: LEN_W];
  assign r_hits  = rdata_q[IDW+TIME_W +: HITS_W];
  assign r_time  = rdata_q[IDW +: TIME_W];
  assign r_id    = rdata_q[IDW-1:0];

  assign age      = now_i - r_time;
  assign hits_inc = (r_hits == HITS_MAX) ? r_hits : r_hits + 16'd1;
  // Rows past the end of the table in the last cells never take an ID.
  assign exists   = ({1'b0, s1_addr_q} < (AW+1)'(ENTRIES));

  assign hit_now  = s1_vld_q & ctrl_i.obs & r_valid & (r_len == qlen_i) & (r_id == qid_i);
  assign old_now  = s1_vld_q & ctrl_i.sweep & r_valid & (age >= TIME_W'(max_age_i));
  assign free_now = s1_vld_q & ctrl_i.obs & ~r_valid & exists;
  assign take     = tok_i & free_q;

  always_comb begin
    we    = 1'b0;
    waddr = s1_addr_q;
    wdata = rdata_q;
    if (ctrl_i.clear) begin
      we    = 1'b1;
      waddr = addr_i;
      wdata = '0;
    end else if (take) begin
      we    = 1'b1;
      waddr = free_addr_q;
      wdata = {1'b1, qlen_i, 16'd1, now_i, qid_i};
    end else if (hit_now) begin
      we    = 1'b1;
      wdata = {1'b1, r_len, hits_inc, now_i, r_id};
    end else if (old_now) begin
      we    = 1'b1;
      wdata = {1'b0, rdata_q[ENW-2:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s1_addr_q   <= '0;
      hit_q       <= 1'b0;
      hits_q      <= '0;
      evict_q     <= '0;
      free_q      <= 1'b0;
      free_addr_q <= '0;
      hit_o_q     <= '0;
      evict_o_q   <= '0;
      tok_q       <= 1'b0;
    end else begin
      s1_vld_q  <= ctrl_i.rd_en;
      s1_addr_q <= addr_i;
      if (ctrl_i.start) begin
        hit_q   <= 1'b0;
        evict_q <= '0;
        free_q  <= 1'b0;
      end else begin
        if (hit_now) begin
          hit_q  <= 1'b1;
          hits_q <= hits_inc;
        end
        if (old_now) begin
          evict_q <= evict_q + 1'b1;
        end
        // Remember the first free row of this bank.
        if (free_now && !free_q) begin
          free_q      <= 1'b1;
          free_addr_q <= s1_addr_q;
        end
        if (take) begin
          free_q <= 1'b0;
        end
      end
      // Merge this cell's summary into the word coming from the left neighbor.
      hit_o_q.hit  <= hit_i.hit | hit_q;
      hit_o_q.hits <= hit_q ? hits_q : hit_i.hits;
      evict_o_q    <= evict_i + evict_q;
      // Pass the insert token on unless this cell consumes it.
      tok_q        <= tok_i & ~free_q;
    end
  end

  assign hit_o   = hit_o_q;
  assign evict_o = evict_o_q;
  assign tok_o   = tok_q;

endmodule

>>> src/seen_id_table_with_age_out.sv
// Top level of the seen-ID table with age-out: handshakes, registers, sequencer, cell row.
//
//  Channel   Direction  Payload                                     Handshake
//  s_axis    in         tuser: opcode; tdata: id_low, id_high, len  tvalid / tready
//  m_axis    out        tdata: is_new, stored, hits, used, evicted  tvalid / tready
//  apb       in/out     max_age (0x0), sweep_period (0x4)           psel / penable, pready = 1
//
// The table is split over SEEN_NUM_CELLS cells of BANK = ceil(TABLE_DEPTH / cells) rows.
// An observe word or a sweeping tick walks the banks one row per cycle in parallel, then the
// summaries and, on a miss, the insert token ripple through the cell row; a tick without a
// sweep skips the scan. After reset a clearing pass over every bank row runs before the first
// word is taken. A finished result waits in the output register while the next word is
// accepted; a stalled output holds the sequencer.

`include "seen_id_table_with_age_out_assert.svh"

module seen_id_table_with_age_out import seen_pkg::*; #(
  parameter int TABLE_DEPTH = SEEN_TABLE_DEPTH,
  parameter int ID_BYTES    = SEEN_ID_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [63:0] id_low, [95:64] id_high, [99:96] id_length, [103:100] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] opcode
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] is_new, [1] stored, [17:2] hit_count, [28:18] entries_used, [39:29] evicted
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int NC   = SEEN_NUM_CELLS;
  localparam int BANK = (TABLE_DEPTH + NC - 1) / NC;
  localparam int AW   = (BANK > 1) ? $clog2(BANK) : 1;
  localparam int IDW  = 8 * ID_BYTES;
  localparam int UW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMAX = (BANK + 1 > NC) ? BANK + 1 : NC;
  localparam int CW   = $clog2(CMAX + 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_GATHER = 3'd3;
  localparam logic [2:0] ST_PLACE  = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              obs_q, obs_d;
  logic              sweep_q, sweep_d;
  logic              stored_q, stored_d;
  logic [IDW-1:0]    qid_q;
  logic [LEN_W-1:0]  qlen_q;
  logic [TIME_W-1:0] now_q, now_d;
  logic [AGE_W-1:0]  cd_q, cd_d;
  logic [AGE_W-1:0]  cd_next;
  logic [AGE_W-1:0]  max_age_q;
  logic [AGE_W-1:0]  period_q;
  logic [UW-1:0]     used_q, used_d;
  logic [UW-1:0]     used_new;
  logic              m_valid_q, m_valid_d;
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;

  logic       in_acc;
  logic       is_tick;
  logic       cfg_wr;
  logic       place_tok;
  seen_ctrl_t ctrl;

  seen_hit_t     hit_c [NC+1];
  logic [UW-1:0] ev_c  [NC+1];
  logic          tok_c [NC+1];

  seen_hit_t     hit_tail;
  logic [UW-1:0] ev_tail;
  logic [UW-1:0] ev_eff;
  logic              res_new;
  logic [HITS_W-1:0] res_hits;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_SWEEP_PERIOD) ? {16'b0, period_q} : {16'b0, max_age_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= MAX_AGE_RESET;
      period_q  <= SWEEP_PERIOD_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_AGE) begin
        max_age_q <= pwdata[AGE_W-1:0];
      end else begin
        period_q <= pwdata[AGE_W-1:0];
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign is_tick       = (s_axis_tuser[0] == OP_TICK);
  assign cd_next       = cd_q + 16'd1;

  assign hit_tail = hit_c[NC];
  assign ev_tail  = ev_c[NC];
  assign ev_eff   = sweep_q ? ev_tail : '0;
  assign used_new = used_q + UW'(stored_q) - ev_eff;
  assign res_new  = obs_q & ~hit_tail.hit;
  assign res_hits = !obs_q ? '0 : (hit_tail.hit ? hit_tail.hits : 16'd1);

  assign place_tok = (state_q == ST_PLACE) && (cnt_q == '0);

  always_comb begin
    ctrl.clear = (state_q == ST_CLEAR);
    ctrl.rd_en = (state_q == ST_SCAN) && (cnt_q < CW'(BANK));
    ctrl.start = 1'b0;
    ctrl.obs   = obs_q;
    ctrl.sweep = sweep_q;

    state_d   = state_q;
    cnt_d     = cnt_q;
    obs_d     = obs_q;
    sweep_d   = sweep_q;
    stored_d  = stored_q;
    now_d     = now_q;
    cd_d      = cd_q;
    used_d    = used_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;

    if (m_axis_tvalid && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(BANK - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cnt_d    = '0;
          stored_d = 1'b0;
          if (!is_tick) begin
            obs_d      = 1'b1;
            sweep_d    = 1'b0;
            ctrl.start = 1'b1;
            state_d    = ST_SCAN;
          end else begin
            obs_d = 1'b0;
            now_d = now_q + 32'd1;
            if (cd_next >= period_q) begin
              cd_d       = '0;
              sweep_d    = 1'b1;
              ctrl.start = 1'b1;
              state_d    = ST_SCAN;
            end else begin
              cd_d    = cd_next;
              sweep_d = 1'b0;
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        // The scan runs on past the last row read to drain the read and compare stages.
        if (cnt_q == CW'(BANK + 1)) begin
          cnt_d   = '0;
          state_d = ST_GATHER;
        end
      end
      ST_GATHER: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(NC)) begin
          cnt_d   = '0;
          state_d = (obs_q && !hit_tail.hit) ? ST_PLACE : ST_DONE;
        end
      end
      ST_PLACE: begin
        cnt_d = cnt_q + 1'b1;
        // The token comes out of the last cell only when no bank had room.
        if (cnt_q == CW'(NC)) begin
          cnt_d    = '0;
          stored_d = ~tok_c[NC];
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {OUT_CNT_W'(ev_eff), OUT_CNT_W'(used_new), res_hits, stored_q, res_new};
          used_d    = used_new;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      obs_q     <= 1'b0;
      sweep_q   <= 1'b0;
      stored_q  <= 1'b0;
      now_q     <= '0;
      cd_q      <= '0;
      used_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      obs_q     <= obs_d;
      sweep_q   <= sweep_d;
      stored_q  <= stored_d;
      now_q     <= now_d;
      cd_q      <= cd_d;
      used_q    <= used_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    if (in_acc) begin
      qid_q  <= s_axis_tdata[IDW-1:0];
      qlen_q <= s_axis_tdata[ID_LOW_W+ID_HIGH_W +: LEN_W];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign hit_c[0] = '0;
  assign ev_c[0]  = '0;
  assign tok_c[0] = place_tok;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    localparam int BASE = k * BANK;
    localparam int ENT  = (TABLE_DEPTH <= BASE) ? 0 :
                          ((TABLE_DEPTH - BASE < BANK) ? TABLE_DEPTH - BASE : BANK);

    seen_cell #(
      .BANK    (BANK),
      .AW      (AW),
      .IDW     (IDW),
      .EW      (UW),
      .ENTRIES (ENT)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .addr_i    (cnt_q[AW-1:0]),
      .qid_i     (qid_q),
      .qlen_i    (qlen_q),
      .now_i     (now_q),
      .max_age_i (max_age_q),
      .hit_i     (hit_c[k]),
      .evict_i   (ev_c[k]),
      .tok_i     (tok_c[k]),
      .hit_o     (hit_c[k+1]),
      .evict_o   (ev_c[k+1]),
      .tok_o     (tok_c[k+1])
    );
  end

  `SEEN_ASSERT_NOW(a_used_in_range, 1'b1, used_q <= UW'(TABLE_DEPTH))
  `SEEN_ASSERT_NOW(a_evict_le_used, (state_q == ST_DONE) && sweep_q, ev_tail <= used_q)
  `SEEN_ASSERT_NOW(a_store_only_new, (state_q == ST_DONE) && stored_q, obs_q && !hit_tail.hit)
  `SEEN_ASSERT_NEXT(a_tick_no_sweep_done, in_acc && is_tick && (cd_next < period_q), state_q == ST_DONE)

endmodule
